// ----- rtl/clamped_table_interpolator_defines.svh -----
// assertion macros for the clamped table interpolator
// expects signals named clk and rst in the module that uses them
`ifndef CLAMPED_TABLE_INTERPOLATOR_DEFINES_SVH
`define CLAMPED_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define CTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CTI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/cti_pkg.sv -----
// shared constants and types of the clamped table interpolator
// used by the breakpoint cells, the interpolation unit and the top level
package cti_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int CODE_BITS      = 12;
  localparam int IDX_BITS       = $clog2(TABLE_DEPTH);
  localparam int ENTRY_IDX_BITS = 4;
  localparam int COUNT_BITS     = 5;
  localparam int DIST_BITS      = 8;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = CODE_BITS;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ENTRY_COUNT = 2'd0,
    REG_MIN_CODE    = 2'd1,
    REG_MAX_CODE    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] sample;
    logic [CODE_BITS-1:0] cl;
    logic [CODE_BITS-1:0] cr;
    logic [DIST_BITS-1:0] dl;
    logic [DIST_BITS-1:0] dr;
  } seg_t;

  typedef struct packed {
    logic                 valid;
    logic                 found;
    logic [CODE_BITS-1:0] prev_code;
    logic [DIST_BITS-1:0] prev_dist;
    seg_t                 seg;
  } tok_t;

  typedef struct packed {
    logic                 valid;
    logic [DIST_BITS-1:0] value;
  } res_t;

endpackage

// ----- rtl/cti_cell.sv -----
// one breakpoint cell: holds a table entry and forwards the search token
// depends on cti_pkg
module cti_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cti_pkg::IDX_BITS-1:0] cell_index,
  input  logic [cti_pkg::IDX_BITS-1:0] last_index,
  input  logic                         wr_en,
  input  logic [cti_pkg::CODE_BITS-1:0] wr_code,
  input  logic [cti_pkg::DIST_BITS-1:0] wr_dist,
  input  cti_pkg::tok_t                tok_in,
  output cti_pkg::tok_t                tok_out
);
  import cti_pkg::*;

  logic [CODE_BITS-1:0] code;
  logic [DIST_BITS-1:0] distance;
  tok_t                 tok_next;
  logic                 hit;

  always_comb begin
    hit = tok_in.valid && !tok_in.found && (cell_index != '0) &&
          (cell_index <= last_index) &&
          ((code <= tok_in.seg.sample) || (cell_index == last_index));
    tok_next           = tok_in;
    tok_next.prev_code = code;
    tok_next.prev_dist = distance;
    if (hit) begin
      tok_next.found  = 1'b1;
      tok_next.seg.cl = tok_in.prev_code;
      tok_next.seg.dl = tok_in.prev_dist;
      tok_next.seg.cr = code;
      tok_next.seg.dr = distance;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code     <= wr_code;
      distance <= wr_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ----- rtl/cti_interp.sv -----
// interpolation unit: two multiply steps and a restoring divide with saturation
// depends on cti_pkg
module cti_interp (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cti_pkg::seg_t seg,
  input  logic          take,
  output cti_pkg::res_t res,
  output logic          busy
);
  import cti_pkg::*;

  localparam int D_BITS    = CODE_BITS + 1;
  localparam int PROD_BITS = D_BITS + DIST_BITS + 1;
  localparam int P_BITS    = PROD_BITS + 2;
  localparam int STEP_BITS = $clog2(DIST_BITS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL1 = 6'b000010,
    ST_MUL2 = 6'b000100,
    ST_PREP = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                  state;
  seg_t                    sg;
  logic signed [D_BITS-1:0]    den;
  logic signed [PROD_BITS-1:0] p1;
  logic signed [PROD_BITS-1:0] p2;
  logic [P_BITS-1:0]           rem;
  logic [P_BITS-1:0]           dvs;
  logic [DIST_BITS-1:0]        quo;
  logic [STEP_BITS-1:0]        step;
  logic [DIST_BITS-1:0]        result;

  logic signed [DIST_BITS:0]   dr_s;
  logic signed [DIST_BITS:0]   dd_s;
  logic signed [D_BITS-1:0]    ds_s;
  logic signed [P_BITS-1:0]    pt;
  logic signed [P_BITS-1:0]    pt_abs;
  logic [CODE_BITS-1:0]        qmag;
  logic [P_BITS-1:0]           q_sh8;
  logic [P_BITS-1:0]           q_sh7;
  logic                        ge;

  always_comb begin
    dr_s   = $signed({1'b0, sg.dr});
    dd_s   = $signed({1'b0, sg.dr}) - $signed({1'b0, sg.dl});
    ds_s   = $signed({1'b0, sg.sample}) - $signed({1'b0, sg.cr});
    pt     = P_BITS'(p1) - P_BITS'(p2);
    pt_abs = den[D_BITS-1] ? -pt : pt;
    qmag   = den[D_BITS-1] ? CODE_BITS'(-den) : CODE_BITS'(den);
    q_sh8  = P_BITS'({qmag, 8'd0});
    q_sh7  = P_BITS'({qmag, 7'd0});
    ge     = (rem >= dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            sg    <= seg;
            den   <= $signed({1'b0, seg.cl}) - $signed({1'b0, seg.cr});
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          p1    <= dr_s * den;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          p2    <= dd_s * ds_s;
          state <= ST_PREP;
        end
        ST_PREP: begin
          if (den == '0) begin
            result <= sg.dr;
            state  <= ST_DONE;
          end else if (pt_abs[P_BITS-1] || (pt_abs == '0)) begin
            result <= '0;
            state  <= ST_DONE;
          end else if (P_BITS'(pt_abs) >= q_sh8) begin
            result <= '1;
            state  <= ST_DONE;
          end else begin
            rem   <= P_BITS'(pt_abs);
            dvs   <= q_sh7;
            quo   <= '0;
            step  <= STEP_BITS'(DIST_BITS - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dvs;
          end
          dvs  <= dvs >> 1;
          quo  <= {quo[DIST_BITS-2:0], ge};
          step <= step - 1'b1;
          if (step == '0) begin
            result <= {quo[DIST_BITS-2:0], ge};
            state  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid = (state == ST_DONE);
  assign res.value = result;
  assign busy      = (state != ST_IDLE);

endmodule

// ----- rtl/clamped_table_interpolator.sv -----
// top level of the clamped table interpolator: config registers, clamp,
// breakpoint cell row, interpolation unit and output register
// depends on cti_pkg, cti_cell, cti_interp and the defines header
// A load item writes one breakpoint. A convert item clamps its sample, then a
// search token walks the row of breakpoint cells, one cell per cycle, picking
// the first entry at or below the sample (else the last entry), and the
// interpolation unit finishes with its multiplies and an eight-step
// restoring divide, which it skips when the segment is flat or the result
// saturates. Input is stalled while a conversion is in flight, so one
// conversion is in the block at a time; a finished result can wait at the
// output while the next item is taken.
`include "clamped_table_interpolator_defines.svh"

module clamped_table_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [cti_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [cti_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [cti_pkg::ENTRY_IDX_BITS-1:0] entry_index,
  input  logic [cti_pkg::CODE_BITS-1:0]    entry_code,
  input  logic [cti_pkg::DIST_BITS-1:0]    entry_distance,
  input  logic [cti_pkg::CODE_BITS-1:0]    sample_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cti_pkg::DIST_BITS-1:0]    distance_cm
);
  import cti_pkg::*;

  logic [COUNT_BITS-1:0] entry_count;
  logic [CODE_BITS-1:0]  min_code;
  logic [CODE_BITS-1:0]  max_code;
  logic [IDX_BITS-1:0]   last_index;
  logic [CODE_BITS-1:0]  clamped;
  logic                  in_xfer;
  logic                  load_xfer;
  logic                  conv_xfer;
  logic [TABLE_DEPTH-1:0] wr_en;
  logic [TABLE_DEPTH-1:0] chain_valid;
  tok_t                  tok_head;
  tok_t                  tok [TABLE_DEPTH];
  res_t                  res;
  logic                  interp_busy;
  logic                  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_BITS'(2);
      min_code    <= '0;
      max_code    <= '1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_BITS-1:0];
        REG_MIN_CODE:    min_code    <= cfg_data[CODE_BITS-1:0];
        REG_MAX_CODE:    max_code    <= cfg_data[CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(entry_count) < 2) begin
      last_index = IDX_BITS'(1);
    end else if (int'(entry_count) > TABLE_DEPTH) begin
      last_index = IDX_BITS'(TABLE_DEPTH - 1);
    end else begin
      last_index = IDX_BITS'(int'(entry_count) - 1);
    end
    if (sample_code > max_code) begin
      clamped = max_code;
    end else if (sample_code < min_code) begin
      clamped = min_code;
    end else begin
      clamped = sample_code;
    end
  end

  assign in_xfer   = in_valid && !in_stall;
  assign load_xfer = in_xfer && (kind == KIND_LOAD);
  assign conv_xfer = in_xfer && (kind == KIND_CONVERT);
  assign in_stall  = (|chain_valid) || interp_busy;

  always_comb begin
    tok_head            = '0;
    tok_head.valid      = conv_xfer;
    tok_head.seg.sample = clamped;
  end

  genvar i;
  generate
    for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign wr_en[i]       = load_xfer && (int'(entry_index) == i);
      assign chain_valid[i] = tok[i].valid;
      if (i == 0) begin : g_head
        cti_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cell_index (IDX_BITS'(i)),
          .last_index (last_index),
          .wr_en      (wr_en[i]),
          .wr_code    (entry_code),
          .wr_dist    (entry_distance),
          .tok_in     (tok_head),
          .tok_out    (tok[i])
        );
      end else begin : g_body
        cti_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cell_index (IDX_BITS'(i)),
          .last_index (last_index),
          .wr_en      (wr_en[i]),
          .wr_code    (entry_code),
          .wr_dist    (entry_distance),
          .tok_in     (tok[i-1]),
          .tok_out    (tok[i])
        );
      end
    end
  endgenerate

  assign take = !out_valid || !out_stall;

  cti_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (tok[TABLE_DEPTH-1].valid),
    .seg   (tok[TABLE_DEPTH-1].seg),
    .take  (take),
    .res   (res),
    .busy  (interp_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && take) begin
      out_valid   <= 1'b1;
      distance_cm <= res.value;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `CTI_ASSERT_NXT(a_conv_blocks_input, conv_xfer, in_stall)
  `CTI_ASSERT_IMP(a_single_token, 1'b1, $onehot0(chain_valid))
  `CTI_ASSERT_IMP(a_token_meets_idle_unit, tok[TABLE_DEPTH-1].valid, !interp_busy)
  `CTI_ASSERT_NXT(a_result_held, res.valid && !take, res.valid)

endmodule

// ----- dv/clamped_table_interpolator_tb.sv -----
// self-checking testbench for clamped_table_interpolator: table loads, clamp and
// count settings, directed corner cases and random traffic with idle and stall bursts
// depends on cti_pkg and the clamped_table_interpolator rtl
module clamped_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cti_pkg::*;

  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = TABLE_DEPTH + 13 + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 14;
  localparam int PHASE_ITEMS    = 110;
  localparam int FINAL_ITEMS    = 150;
  localparam int MAX_REPORTS    = 50;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      kind = KIND_LOAD;
  logic [ENTRY_IDX_BITS-1:0] entry_index = '0;
  logic [CODE_BITS-1:0]      entry_code = '0;
  logic [DIST_BITS-1:0]      entry_distance = '0;
  logic [CODE_BITS-1:0]      sample_code = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DIST_BITS-1:0]      distance_cm;

  // predictor state
  logic [COUNT_BITS-1:0]     count_reg = 5'd2;
  logic [CODE_BITS-1:0]      min_reg = '0;
  logic [CODE_BITS-1:0]      max_reg = '1;
  logic [CODE_BITS-1:0]      bp_code [TABLE_DEPTH];
  logic [DIST_BITS-1:0]      bp_dist [TABLE_DEPTH];

  logic [DIST_BITS-1:0]      pending_distances [$];
  int                        mismatches = 0;
  int                        quiet_cycles = 0;
  int                        in_gap_pct = 0;
  int                        out_stall_pct = 0;

  clamped_table_interpolator u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .entry_index    (entry_index),
    .entry_code     (entry_code),
    .entry_distance (entry_distance),
    .sample_code    (sample_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .distance_cm    (distance_cm)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [DIST_BITS-1:0] interpolate_distance(logic [CODE_BITS-1:0] raw);
    int          n;
    int          ri;
    logic        found;
    logic [CODE_BITS-1:0] s;
    longint      dr, dl, cr, cl, num, den, p;
    n = (count_reg < 2) ? 2 : ((count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg));
    s = raw;
    if (s > max_reg) s = max_reg;
    else if (s < min_reg) s = min_reg;
    ri = n - 1;
    found = 1'b0;
    for (int i = 1; i < n; i++) begin
      if (!found && bp_code[i] <= s) begin
        ri = i;
        found = 1'b1;
      end
    end
    dr = longint'(bp_dist[ri]);
    dl = longint'(bp_dist[ri-1]);
    cr = longint'(bp_code[ri]);
    cl = longint'(bp_code[ri-1]);
    num = (dr - dl) * (longint'(s) - cr);
    den = cl - cr;
    if (den == 0) begin
      p = dr;
    end else begin
      p = dr * den - num;
      if (den < 0) begin
        den = -den;
        p = -p;
      end
      p = p / den;
    end
    if (p < 0) return '0;
    if (p > 255) return '1;
    return DIST_BITS'(p);
  endfunction

  function automatic logic [CODE_BITS-1:0] pick_code();
    logic [CODE_BITS-1:0] c;
    case ($urandom_range(0, 9))
      0: c = bp_code[$urandom_range(0, TABLE_DEPTH-1)];
      1: c = bp_code[$urandom_range(0, TABLE_DEPTH-1)] + CODE_BITS'($urandom_range(0, 2)) - 1'b1;
      2: c = $urandom_range(0, 1) ? min_reg : max_reg;
      3: c = $urandom_range(0, 1) ? '0 : '1;
      default: c = CODE_BITS'($urandom_range(0, 4095));
    endcase
    return c;
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_item(logic k, logic [ENTRY_IDX_BITS-1:0] idx, logic [CODE_BITS-1:0] ecode,
                           logic [DIST_BITS-1:0] edist, logic [CODE_BITS-1:0] scode);
    int gap;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    kind           <= k;
    entry_index    <= idx;
    entry_code     <= ecode;
    entry_distance <= edist;
    sample_code    <= scode;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (k == KIND_LOAD) begin
      bp_code[idx] = ecode;
      bp_dist[idx] = edist;
    end else begin
      pending_distances.push_back(interpolate_distance(scode));
    end
  endtask

  task automatic load_entry(logic [ENTRY_IDX_BITS-1:0] idx, logic [CODE_BITS-1:0] ecode,
                            logic [DIST_BITS-1:0] edist);
    send_item(KIND_LOAD, idx, ecode, edist, CODE_BITS'($urandom_range(0, 4095)));
  endtask

  task automatic convert(logic [CODE_BITS-1:0] scode);
    send_item(KIND_CONVERT, ENTRY_IDX_BITS'($urandom_range(0, 15)),
              CODE_BITS'($urandom_range(0, 4095)), DIST_BITS'($urandom_range(0, 255)), scode);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (r)
      REG_ENTRY_COUNT: count_reg = v[COUNT_BITS-1:0];
      REG_MIN_CODE:    min_reg = v;
      REG_MAX_CODE:    max_reg = v;
      default: ;
    endcase
  endtask

  task automatic write_random_setup();
    int a, b;
    case ($urandom_range(0, 9))
      0: write_reg(REG_ENTRY_COUNT, 12'd2);
      1: write_reg(REG_ENTRY_COUNT, 12'd16);
      2: write_reg(REG_ENTRY_COUNT, CFG_DATA_BITS'($urandom_range(0, 1)));
      3: write_reg(REG_ENTRY_COUNT, CFG_DATA_BITS'($urandom_range(17, 31)));
      default: write_reg(REG_ENTRY_COUNT, CFG_DATA_BITS'($urandom_range(2, 16)));
    endcase
    a = $urandom_range(0, 4095);
    b = $urandom_range(0, 4095);
    case ($urandom_range(0, 5))
      0: begin
        a = 0;
        b = 4095;
      end
      1: if (a < b) begin
        a = a + b;
        b = a - b;
        a = a - b;
      end
      default: if (a > b) begin
        a = a + b;
        b = a - b;
        a = a - b;
      end
    endcase
    write_reg(REG_MIN_CODE, CFG_DATA_BITS'(a));
    write_reg(REG_MAX_CODE, CFG_DATA_BITS'(b));
  endtask

  task automatic load_descending_table();
    int c, d;
    c = $urandom_range(2500, 4095);
    d = $urandom_range(0, 80);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_entry(ENTRY_IDX_BITS'(i), CODE_BITS'(c), DIST_BITS'(d));
      c = c - int'($urandom_range(0, 350));
      if (c < 0) c = 0;
      d = d + int'($urandom_range(0, 35));
      if (d > 255) d = 255;
    end
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      load_entry(ENTRY_IDX_BITS'(i), CODE_BITS'(4095 - i * 273), DIST_BITS'(i * 17));
    end
    convert(12'd4095);
    convert(12'd0);
    convert(12'd3900);
  endtask

  task automatic test_clamp_and_count();
    wait_drained();
    write_reg(REG_ENTRY_COUNT, 12'd16);
    convert(12'd0);
    convert(12'd2048);
    convert(bp_code[7]);
    wait_drained();
    write_reg(REG_ENTRY_COUNT, 12'd0);
    convert(12'd1000);
    wait_drained();
    write_reg(REG_ENTRY_COUNT, 12'd31);
    convert(12'd1000);
    // crossed clamps
    wait_drained();
    write_reg(REG_MIN_CODE, 12'd3000);
    write_reg(REG_MAX_CODE, 12'd1000);
    convert(12'd4095);
    convert(12'd2000);
    convert(12'd500);
    wait_drained();
    write_reg(REG_MIN_CODE, 12'd1000);
    write_reg(REG_MAX_CODE, 12'd3000);
    convert(12'd0);
    convert(12'd4095);
  endtask

  task automatic test_table_corners();
    wait_drained();
    write_reg(REG_ENTRY_COUNT, 12'd16);
    write_reg(REG_MIN_CODE, 12'd0);
    write_reg(REG_MAX_CODE, 12'd4095);
    // first entry below the second: negative divisor
    load_entry(4'd0, 12'd100, 8'd255);
    convert(12'd3900);
    convert(12'd4095);
    // no match falls to a flat last segment
    load_entry(4'd14, 12'd500, 8'd255);
    load_entry(4'd15, 12'd500, 8'd60);
    convert(12'd100);
    convert(12'd0);
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      write_random_setup();
      if ($urandom_range(0, 3) == 0) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(10, 40);
        out_stall_pct = $urandom_range(5, 25);
      end
      if (ph == 0 || $urandom_range(0, 2) == 0) load_descending_table();
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          load_entry(ENTRY_IDX_BITS'($urandom_range(0, 15)), CODE_BITS'($urandom_range(0, 4095)),
                     DIST_BITS'($urandom_range(0, 255)));
        end else begin
          convert(pick_code());
        end
      end
    end
  endtask

  task automatic test_unthrottled();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    wait_drained();
    write_random_setup();
    load_descending_table();
    repeat (FINAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        load_entry(ENTRY_IDX_BITS'($urandom_range(0, 15)), CODE_BITS'($urandom_range(0, 4095)),
                   DIST_BITS'($urandom_range(0, 255)));
      end else begin
        convert(pick_code());
      end
    end
  endtask

  // receiver stall bursts
  initial begin : stall_bursts
    int n;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < out_stall_pct) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: distance_cm expected none actual %0d", $time, distance_cm);
      end else if (distance_cm !== pending_distances[0]) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: distance_cm expected %0d actual %0d", $time, pending_distances[0],
                   distance_cm);
        void'(pending_distances.pop_front());
      end else begin
        void'(pending_distances.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_clamp_and_count();
    test_table_corners();
    test_random_mix();
    test_unthrottled();
    wait_drained();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cti_pkg.sv
rtl/cti_cell.sv
rtl/cti_interp.sv
rtl/clamped_table_interpolator.sv
dv/clamped_table_interpolator_tb.sv
